// ===== sv/slbg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the smoothed LED bar graph.
// No dependencies; every other file in this folder refers to it by scoped names.
package slbg_pkg;

    localparam int DIGITS_DEFAULT = 8;
    localparam int MAX_EMIT       = 8;

    localparam int VAL_W    = 21;   // 5.16 fixed point average
    localparam int LEVEL_W  = 5;    // integer part of the average
    localparam int WEIGHT_W = 9;
    localparam int DIGIT_W  = 3;
    localparam int SEG_W    = 7;
    localparam int INDEX_W  = 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL           = 9'd256;
    localparam logic [WEIGHT_W-1:0] THRUSTER_WEIGHT_RESET = 9'd130;
    localparam logic [WEIGHT_W-1:0] BOOSTER_WEIGHT_RESET  = 9'd16;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_THRUSTER_WEIGHT = 1'b0;
    localparam logic [INDEX_W-1:0] REG_BOOSTER_WEIGHT  = 1'b1;

    // Segment patterns for each bar.
    localparam logic [SEG_W-1:0] SEG_FRONT_LEFT  = 7'b1000000;
    localparam logic [SEG_W-1:0] SEG_REAR        = 7'b0000001;
    localparam logic [SEG_W-1:0] SEG_FRONT_RIGHT = 7'b0001000;
    localparam logic [SEG_W-1:0] SEG_BOOST_LOW   = 7'b0000110;
    localparam logic [SEG_W-1:0] SEG_BOOST_HIGH  = 7'b0110000;

    // Bar lengths of the four channels after one refresh.
    typedef struct packed {
        logic [LEVEL_W-1:0] front_left;
        logic [LEVEL_W-1:0] rear;
        logic [LEVEL_W-1:0] front_right;
        logic [LEVEL_W-1:0] booster;
    } levels_t;

endpackage

// ===== sv/slbg_lane.sv =====
`timescale 1ns / 1ps
// One smoothing lane: holds a 5.16 moving average and updates it per refresh.
// Depends on slbg_pkg.
module slbg_lane
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             flag,
    input  logic [slbg_pkg::WEIGHT_W-1:0]    weight,
    output logic [slbg_pkg::LEVEL_W-1:0]     level_next
);

    localparam int ACC_W = slbg_pkg::VAL_W + slbg_pkg::WEIGHT_W;

    logic [slbg_pkg::VAL_W-1:0]    value_reg;
    logic [slbg_pkg::VAL_W-1:0]    value_next;
    logic [slbg_pkg::WEIGHT_W-1:0] w_sat;
    logic [slbg_pkg::WEIGHT_W-1:0] w_keep;
    logic [ACC_W-1:0]              keep_term;
    logic [ACC_W-1:0]              sample_term;
    logic [ACC_W-1:0]              acc;

    // A weight above 256 saturates, so the new sample is taken whole.
    assign w_sat  = (weight > slbg_pkg::WEIGHT_FULL) ? slbg_pkg::WEIGHT_FULL : weight;
    assign w_keep = slbg_pkg::WEIGHT_FULL - w_sat;

    assign keep_term   = ACC_W'(value_reg) * ACC_W'(w_keep);
    // The full sample is 16.0, i.e. 1 << 20, so its product is a shift.
    assign sample_term = flag ? {1'b0, w_sat, 20'd0} : '0;
    assign acc         = keep_term + sample_term;
    assign value_next  = acc[8 +: slbg_pkg::VAL_W];

    assign level_next = value_next[slbg_pkg::VAL_W-1 -: slbg_pkg::LEVEL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== sv/slbg_merge.sv =====
`timescale 1ns / 1ps
// Merging stage: buffers one set of bar lengths and walks the digits, ORing the
// bars of all lanes into one segment byte per cycle when not stalled. Depends on slbg_pkg.
module slbg_merge
#(
    parameter int DIGITS = slbg_pkg::DIGITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  slbg_pkg::levels_t                 levels,
    output logic                              full,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slbg_pkg::DIGIT_W-1:0]      digit_index,
    output logic [slbg_pkg::SEG_W-1:0]        segments,
    output logic                              last
);

    localparam int EMIT = (DIGITS > slbg_pkg::MAX_EMIT) ? slbg_pkg::MAX_EMIT : DIGITS;
    localparam logic [slbg_pkg::DIGIT_W-1:0] LAST_DIGIT = slbg_pkg::DIGIT_W'(EMIT - 1);

    logic                              pend_valid_reg;
    slbg_pkg::levels_t                 pend_levels_reg;
    logic                              act_valid_reg;
    slbg_pkg::levels_t                 act_levels_reg;
    logic [slbg_pkg::DIGIT_W-1:0]      digit_reg;
    logic                              out_valid_reg;
    logic [slbg_pkg::DIGIT_W-1:0]      out_digit_reg;
    logic [slbg_pkg::SEG_W-1:0]        out_seg_reg;
    logic                              out_last_reg;

    logic                              step;
    logic                              at_last;
    logic                              promote;
    logic [slbg_pkg::LEVEL_W-1:0]      twice;
    logic [slbg_pkg::LEVEL_W-1:0]      twice_plus;
    logic [slbg_pkg::SEG_W-1:0]        seg_next;

    assign step       = act_valid_reg && (!out_valid_reg || out_ready);
    assign at_last    = (digit_reg == LAST_DIGIT);
    assign promote    = pend_valid_reg && (!act_valid_reg || (step && at_last));
    assign twice      = {1'b0, digit_reg, 1'b0};
    assign twice_plus = {1'b0, digit_reg, 1'b1};

    always_comb
    begin
        seg_next = '0;
        if (twice < act_levels_reg.front_left)
            seg_next = seg_next | slbg_pkg::SEG_FRONT_LEFT;
        if (twice < act_levels_reg.rear)
            seg_next = seg_next | slbg_pkg::SEG_REAR;
        if (twice < act_levels_reg.front_right)
            seg_next = seg_next | slbg_pkg::SEG_FRONT_RIGHT;
        if (twice < act_levels_reg.booster)
            seg_next = seg_next | slbg_pkg::SEG_BOOST_LOW;
        if (twice_plus < act_levels_reg.booster)
            seg_next = seg_next | slbg_pkg::SEG_BOOST_HIGH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            digit_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
                pend_valid_reg <= 1'b1;
            else if (promote)
                pend_valid_reg <= 1'b0;

            if (promote)
            begin
                act_valid_reg <= 1'b1;
                digit_reg     <= '0;
            end
            else if (step && at_last)
            begin
                act_valid_reg <= 1'b0;
            end
            else if (step)
            begin
                digit_reg <= digit_reg + 1'b1;
            end

            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pend_levels_reg <= levels;
        if (promote)
            act_levels_reg <= pend_levels_reg;
        if (step)
        begin
            out_digit_reg <= digit_reg;
            out_seg_reg   <= seg_next;
            out_last_reg  <= at_last;
        end
    end

    assign full        = pend_valid_reg;
    assign out_valid   = out_valid_reg;
    assign digit_index = out_digit_reg;
    assign segments    = out_seg_reg;
    assign last        = out_last_reg;

endmodule

// ===== sv/smoothed_led_bar_graph.sv =====
`timescale 1ns / 1ps
// Top level of the smoothed LED bar graph: four smoothing lanes and the digit merger.
// Depends on slbg_pkg, slbg_lane and slbg_merge.
//
// Usage:
// Each request on the input channel (in_valid / in_ready) is one refresh tick
// carrying four on/off flags. At acceptance every lane updates its moving
// average in the same cycle, and the integer parts are parked in a one-entry
// buffer in front of the digit merger.
// The output channel (out_valid / out_ready) then carries one request per
// digit, digit 0 first, with last set on the final digit. At most eight
// digits are produced, since the digit index is three bits wide.
// The tick passes the buffer, the merger's active set and the output register on its way.
// Throughput: one digit per cycle while the receiver does not stall, set by the
// merger's one segment byte a cycle; a single-digit build cannot keep that rate across ticks.
// A new tick is accepted while the previous one is still being emitted; the
// buffer holds it until the merger is free, and in_ready drops only while
// that buffer is occupied.
// When the receiver stalls, the output register holds its request and the
// merger stops; the input side keeps going until the buffer is full.
// Configuration writes (cfg_valid / cfg_ready) are always taken and must be
// made while the block is idle. Reset clears all averages to zero and loads
// the weights with 130 for the thrusters and 16 for the booster.
module smoothed_led_bar_graph
#(
    parameter int DIGITS = slbg_pkg::DIGITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              front_left_on,
    input  logic                              rear_on,
    input  logic                              front_right_on,
    input  logic                              booster_on,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slbg_pkg::DIGIT_W-1:0]      digit_index,
    output logic [slbg_pkg::SEG_W-1:0]        segments,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slbg_pkg::INDEX_W-1:0]      cfg_index,
    input  logic [slbg_pkg::WEIGHT_W-1:0]     cfg_data
);

    logic [slbg_pkg::WEIGHT_W-1:0] thruster_weight_reg;
    logic [slbg_pkg::WEIGHT_W-1:0] booster_weight_reg;
    logic                          accept;
    logic                          merge_full;
    slbg_pkg::levels_t             levels;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thruster_weight_reg <= slbg_pkg::THRUSTER_WEIGHT_RESET;
            booster_weight_reg  <= slbg_pkg::BOOSTER_WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slbg_pkg::REG_THRUSTER_WEIGHT: thruster_weight_reg <= cfg_data;
                slbg_pkg::REG_BOOSTER_WEIGHT:  booster_weight_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // A tick is taken whenever the merger's buffer is free.
    assign in_ready = !merge_full;
    assign accept   = in_valid && in_ready;

    // The three skinny bars share the thruster weight; the booster has its own.
    slbg_lane u_lane_front_left
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .flag       (front_left_on),
        .weight     (thruster_weight_reg),
        .level_next (levels.front_left)
    );

    slbg_lane u_lane_rear
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .flag       (rear_on),
        .weight     (thruster_weight_reg),
        .level_next (levels.rear)
    );

    slbg_lane u_lane_front_right
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .flag       (front_right_on),
        .weight     (thruster_weight_reg),
        .level_next (levels.front_right)
    );

    slbg_lane u_lane_booster
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .flag       (booster_on),
        .weight     (booster_weight_reg),
        .level_next (levels.booster)
    );

    // The merger turns the four bar lengths into one segment byte per digit.
    slbg_merge
    #(
        .DIGITS (DIGITS)
    )
    u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .levels      (levels),
        .full        (merge_full),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_index (digit_index),
        .segments    (segments),
        .last        (last)
    );

endmodule

// ===== sv/slbg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the smoothed LED bar graph, bound to the top level.
// Depends on slbg_pkg and smoothed_led_bar_graph.
module slbg_checker
#(
    parameter int DIGITS = slbg_pkg::DIGITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [slbg_pkg::DIGIT_W-1:0]      digit_index,
    input  logic [slbg_pkg::SEG_W-1:0]        segments,
    input  logic                              last
);

    localparam int EMIT = (DIGITS > slbg_pkg::MAX_EMIT) ? slbg_pkg::MAX_EMIT : DIGITS;
    localparam logic [slbg_pkg::DIGIT_W-1:0] LAST_DIGIT = slbg_pkg::DIGIT_W'(EMIT - 1);

    // A stalled request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(digit_index) && $stable(segments) && $stable(last))
    else $error("output request changed while stalled");

    // Within a tick the digits follow each other without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && (digit_index == $past(digit_index) + 1'b1))
    else $error("digit sequence broken within a tick");

    // After the final digit, a following tick starts at digit zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid || (digit_index == '0))
    else $error("new tick does not start at digit zero");

    // The last marker goes on the final digit only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (digit_index == LAST_DIGIT)))
    else $error("last marker on the wrong digit");

endmodule

bind smoothed_led_bar_graph slbg_checker
#(
    .DIGITS (DIGITS)
)
u_slbg_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_index (digit_index),
    .segments    (segments),
    .last        (last)
);

// ===== tb/smoothed_led_bar_graph_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the smoothed LED bar graph: drives refresh ticks and weight
// writes, predicts every segment byte and compares it with the block's output.
// Depends on slbg_pkg and smoothed_led_bar_graph.
module smoothed_led_bar_graph_test;

    import slbg_pkg::*;

    // Bit positions of the four flags in a tick, which are also the average indexes.
    localparam int CH_FRONT_LEFT  = 0;
    localparam int CH_REAR        = 1;
    localparam int CH_FRONT_RIGHT = 2;
    localparam int CH_BOOSTER     = 3;

    // The block is built with its default digit count; it never emits more than eight.
    localparam int DIGITS    = DIGITS_DEFAULT;
    localparam int EMITTED   = (DIGITS > MAX_EMIT) ? MAX_EMIT : DIGITS;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 32;
    // Worst case is about 300 ticks of eight bytes, each byte waiting out the
    // longest receiver stall, plus sender gaps and drains.
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [31:0] FULL_SAMPLE = 32'd16 << 16;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [SEG_W-1:0]   seg;
        logic               last;
    } digit_byte_t;

    // Shadow of the block: its own weights and averages, plus the segment bytes
    // that still have to come out, oldest first.
    class bar_graph_shadow;
        logic [WEIGHT_W-1:0] thruster_weight;
        logic [WEIGHT_W-1:0] booster_weight;
        logic [VAL_W-1:0]    average[4];
        digit_byte_t         pending_bytes[$];
        int                  mismatches;

        function new();
            thruster_weight = THRUSTER_WEIGHT_RESET;
            booster_weight  = BOOSTER_WEIGHT_RESET;
            foreach (average[ch])
                average[ch] = '0;
            mismatches = 0;
        endfunction

        function void set_weight(logic [INDEX_W-1:0] index, logic [WEIGHT_W-1:0] data);
            if (index == REG_THRUSTER_WEIGHT)
                thruster_weight = data;
            else if (index == REG_BOOSTER_WEIGHT)
                booster_weight = data;
        endfunction

        // One step of the moving average; weights above full scale saturate.
        function logic [VAL_W-1:0] smooth(logic [VAL_W-1:0] old, logic [WEIGHT_W-1:0] weight,
                                          logic flag);
            logic [31:0] w;
            logic [31:0] acc;
            w   = (weight > WEIGHT_FULL) ? 32'(WEIGHT_FULL) : 32'(weight);
            acc = 32'(old) * (32'd256 - w) + (flag ? FULL_SAMPLE : 32'd0) * w;
            return acc[VAL_W+7:8];
        endfunction

        function void note_tick(logic [3:0] flags);
            int          level[4];
            int          twice;
            digit_byte_t b;
            average[CH_FRONT_LEFT]  = smooth(average[CH_FRONT_LEFT], thruster_weight,
                                             flags[CH_FRONT_LEFT]);
            average[CH_REAR]        = smooth(average[CH_REAR], thruster_weight,
                                             flags[CH_REAR]);
            average[CH_FRONT_RIGHT] = smooth(average[CH_FRONT_RIGHT], thruster_weight,
                                             flags[CH_FRONT_RIGHT]);
            average[CH_BOOSTER]     = smooth(average[CH_BOOSTER], booster_weight,
                                             flags[CH_BOOSTER]);
            foreach (level[ch])
                level[ch] = int'(average[ch][VAL_W-1:16]);
            for (int d = 0; d < EMITTED; d++)
            begin
                twice  = 2 * d;
                b.digit = DIGIT_W'(d);
                b.seg   = '0;
                if (twice < level[CH_FRONT_LEFT])
                    b.seg |= SEG_FRONT_LEFT;
                if (twice < level[CH_REAR])
                    b.seg |= SEG_REAR;
                if (twice < level[CH_FRONT_RIGHT])
                    b.seg |= SEG_FRONT_RIGHT;
                if (twice < level[CH_BOOSTER])
                    b.seg |= SEG_BOOST_LOW;
                if (twice + 1 < level[CH_BOOSTER])
                    b.seg |= SEG_BOOST_HIGH;
                b.last = (d == EMITTED - 1);
                pending_bytes.push_back(b);
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_digit(logic [DIGIT_W-1:0] digit, logic [SEG_W-1:0] seg, logic last);
            digit_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte digit=%0d segments=%b last=%b",
                                 digit, seg, last));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (digit !== want.digit)
                    report($sformatf("digit_index %0d, expected %0d", digit, want.digit));
                if (seg !== want.seg)
                    report($sformatf("segments %b on digit %0d, expected %b",
                                     seg, want.digit, want.seg));
                if (last !== want.last)
                    report($sformatf("last %b on digit %0d, expected %b",
                                     last, want.digit, want.last));
            end
        endtask

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                front_left_on  = 1'b0;
    logic                rear_on        = 1'b0;
    logic                front_right_on = 1'b0;
    logic                booster_on     = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [DIGIT_W-1:0]  digit_index;
    logic [SEG_W-1:0]    segments;
    logic                last;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index      = '0;
    logic [WEIGHT_W-1:0] cfg_data       = '0;

    bar_graph_shadow sb = new();

    // When set, neither side idles any more: the closing stretch of the run.
    bit calm = 1'b0;
    // Chance, in percent, that the sender pauses before a request.
    int sender_pause_pct = 25;
    int cycle_count = 0;

    smoothed_led_bar_graph #(.DIGITS(DIGITS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .front_left_on  (front_left_on),
        .rear_on        (rear_on),
        .front_right_on (front_right_on),
        .booster_on     (booster_on),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_index    (digit_index),
        .segments       (segments),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost byte ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output monitor. Values sampled at the edge are the ones from before it,
    // both for the block's outputs and for our own out_ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_digit(digit_index, segments, last);
    end

    // Receiver: ready runs broken now and then by stall bursts. Some runs
    // are long, so there are stretches without any stall as well.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    // Present one tick and hold it until the block takes it. The request is
    // noted in the shadow at the edge it is accepted. Valid is left high on
    // return so that a following tick can go out back to back.
    task send_tick(input logic [3:0] flags);
        in_valid       <= 1'b1;
        front_left_on  <= flags[CH_FRONT_LEFT];
        rear_on        <= flags[CH_REAR];
        front_right_on <= flags[CH_FRONT_RIGHT];
        booster_on     <= flags[CH_BOOSTER];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_tick(flags);
    endtask

    // Sender gap between ticks: with chance sender_pause_pct, a burst of idle cycles.
    task sender_gap();
        if (!calm && $urandom_range(1, 100) <= sender_pause_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task tick(input logic [3:0] flags);
        sender_gap();
        send_tick(flags);
    endtask

    // Let the block run dry until every predicted byte is out, and let it idle
    // afterwards so nothing is left in flight before a write.
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task write_weight(input logic [INDEX_W-1:0] index, input logic [WEIGHT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_weight(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Weights lean on the edges: zero, one, just under, at and just over full
    // scale, the all-ones code, and now and then anything in range.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd255;
            3:       return WEIGHT_FULL;
            4:       return 9'd257;
            5:       return 9'h1FF;
            default: return WEIGHT_W'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic int pick_duty();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 10;
            2:       return 50;
            3:       return 90;
            default: return 100;
        endcase
    endfunction

    initial
    begin
        int          duty[4];
        logic [3:0]  flags;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First with the reset weights, so their values are
        // checked too: thrusters jump halfway, the booster creeps up slowly.
        tick(4'b1111);
        tick(4'b1111);
        tick(4'b1111);
        tick(4'b0000);
        drain();

        // Full-scale weights: one tick takes the sample at once, so bars go
        // straight from empty to all digits lit and back, one channel at a time.
        write_weight(REG_THRUSTER_WEIGHT, WEIGHT_FULL);
        write_weight(REG_BOOSTER_WEIGHT, WEIGHT_FULL);
        tick(4'b1111);
        tick(4'b0000);
        tick(4'b0001);
        tick(4'b0010);
        tick(4'b0100);
        tick(4'b1000);
        tick(4'b1111);
        drain();

        // Zero weight: the averages hold their values whatever the flags say.
        write_weight(REG_THRUSTER_WEIGHT, 9'd0);
        write_weight(REG_BOOSTER_WEIGHT, 9'd0);
        tick(4'b0000);
        tick(4'b1010);
        drain();

        // Weights past full scale saturate and behave like full scale.
        write_weight(REG_THRUSTER_WEIGHT, 9'h1FF);
        write_weight(REG_BOOSTER_WEIGHT, 9'd300);
        tick(4'b0101);
        tick(4'b1010);
        drain();

        // Smallest nonzero and just under full scale.
        write_weight(REG_THRUSTER_WEIGHT, 9'd1);
        write_weight(REG_BOOSTER_WEIGHT, 9'd255);
        tick(4'b1111);
        tick(4'b0110);
        drain();

        // Random part. Each phase has its own weights and a duty cycle per flag,
        // so averages are driven to the rails, held in the middle, or dither.
        // The last phase runs without idling on either side.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_weight(REG_THRUSTER_WEIGHT, pick_weight());
            write_weight(REG_BOOSTER_WEIGHT, pick_weight());
            foreach (duty[ch])
                duty[ch] = pick_duty();
            sender_pause_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            if (phase == PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                foreach (duty[ch])
                    flags[ch] = ($urandom_range(1, 100) <= duty[ch]);
                tick(flags);
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
